>>> design/llbd_pkg.sv
// Shared constants, types and saturating helpers for the least-loaded batch dispatcher.
package llbd_pkg;

  localparam int MAX_BATCHES = 8;
  localparam int BATCH_W     = $clog2(MAX_BATCHES);
  localparam int CNT_W       = $clog2(MAX_BATCHES + 1);

  localparam int LOAD_W  = 32;
  localparam int COUNT_W = 16;
  localparam int TOK_W   = 20;
  localparam int THR_W   = 34;
  localparam int PCT_W   = 8;
  localparam int BIDX_W  = 3;

  // Divider datapath: wide dividend, narrow constant-like divisor, one digit per cycle.
  localparam int SUM_W     = 40;
  localparam int DVS_W     = 8;
  localparam int DIGIT_W   = 4;
  localparam int DIV_STEPS = SUM_W / DIGIT_W;
  localparam int DSTEP_W   = $clog2(DIV_STEPS);

  localparam int TOKENS_PER_BLOCK = 200;
  localparam int MIN_REQS         = 5;
  localparam int PCT_SCALE        = 100;

  localparam int IN_DATA_W  = 120;
  localparam int IN_USER_W  = 3;
  localparam int OUT_DATA_W = 160;
  localparam int OUT_USER_W = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_COST_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 2'd2;

  typedef enum logic [1:0] {
    REQ_PRESET   = 2'd0,
    REQ_DISPATCH = 2'd1,
    REQ_OFFLOAD  = 2'd2
  } req_type_t;

  typedef enum logic [1:0] {
    MODE_NONE      = 2'd0,
    MODE_PER_REQ   = 2'd1,
    MODE_FWD_BLOCK = 2'd2,
    MODE_NEW_TOK   = 2'd3
  } cost_mode_t;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_NO_BATCH = 2'd1,
    STAT_OFF_SKIP = 2'd2,
    STAT_FEW_REQ  = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_COST,
    ST_PRE_RD,
    ST_PRE_WR,
    ST_SCAN,
    ST_WRITE,
    ST_CHECK,
    ST_DIV_AVG,
    ST_MUL,
    ST_THR_GO,
    ST_DIV_THR,
    ST_FIN,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic [LOAD_W-1:0]  dec_load;
    logic [LOAD_W-1:0]  wait_load;
    logic [COUNT_W-1:0] dec_cnt;
    logic [COUNT_W-1:0] wait_cnt;
  } entry_t;

  typedef struct packed {
    logic [BIDX_W-1:0] chosen;
    logic [TOK_W-1:0]  cost;
    logic [LOAD_W-1:0] new_load;
    logic              need;
    logic [LOAD_W-1:0] ideal;
    logic [THR_W-1:0]  thr;
    logic [LOAD_W-1:0] move;
    status_t           status;
  } result_t;

  function automatic logic [LOAD_W-1:0] sat_add(input logic [LOAD_W-1:0] a,
                                                input logic [LOAD_W-1:0] b);
    logic [LOAD_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[LOAD_W] ? {LOAD_W{1'b1}} : s[LOAD_W-1:0];
  endfunction

  function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] a);
    return (a == {COUNT_W{1'b1}}) ? a : a + 1'b1;
  endfunction

  function automatic logic [LOAD_W-1:0] entry_total(input entry_t e);
    return sat_add(e.dec_load, e.wait_load);
  endfunction

endpackage

>>> design/llbd_state_mem.sv
// Per-batch load and count memory with registered read and reset-cleared valid bits.
module llbd_state_mem (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         rd_en,
  input  logic [llbd_pkg::BATCH_W-1:0] rd_addr,
  output llbd_pkg::entry_t             rd_data,
  input  logic                         wr_en,
  input  logic [llbd_pkg::BATCH_W-1:0] wr_addr,
  input  llbd_pkg::entry_t             wr_data
);
  import llbd_pkg::*;

  entry_t                 mem_r [MAX_BATCHES];
  logic [MAX_BATCHES-1:0] valid_r;
  entry_t                 rd_q_r;
  logic                   rd_vld_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q_r <= mem_r[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (wr_en) begin
        valid_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld_r <= valid_r[rd_addr];
      end
    end
  end

  // An entry never written since reset reads as zero.
  assign rd_data = rd_vld_r ? rd_q_r : '0;

endmodule

>>> design/llbd_div.sv
// Iterative unsigned divider retiring four quotient bits per cycle.
module llbd_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [llbd_pkg::SUM_W-1:0] dividend,
  input  logic [llbd_pkg::DVS_W-1:0] divisor,
  output logic                       done,
  output logic [llbd_pkg::SUM_W-1:0] quotient,
  output logic [llbd_pkg::DVS_W-1:0] remainder
);
  import llbd_pkg::*;

  logic               busy_r;
  logic               done_r;
  logic [DSTEP_W-1:0] step_r;
  logic [SUM_W-1:0]   num_r;
  logic [SUM_W-1:0]   quo_r;
  logic [DVS_W-1:0]   rem_r;
  logic [DVS_W-1:0]   dvs_r;
  logic [DVS_W-1:0]   rem_nxt;
  logic [DIGIT_W-1:0] qdig;

  always_comb begin
    logic [DVS_W:0] t;
    logic [DVS_W-1:0] r;
    r    = rem_r;
    qdig = '0;
    for (int i = 0; i < DIGIT_W; i++) begin
      t = {r, num_r[SUM_W-1-i]};
      if (t >= {1'b0, dvs_r}) begin
        t = t - {1'b0, dvs_r};
        qdig[DIGIT_W-1-i] = 1'b1;
      end
      r = t[DVS_W-1:0];
    end
    rem_nxt = r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (busy_r) begin
        step_r <= step_r + 1'b1;
        if (step_r == DSTEP_W'(DIV_STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num_r <= dividend;
      quo_r <= '0;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      num_r <= {num_r[SUM_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
      quo_r <= {quo_r[SUM_W-DIGIT_W-1:0], qdig};
      rem_r <= rem_nxt;
    end
  end

  assign done      = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule

>>> design/least_loaded_batch_dispatcher_unit.sv
// Top level of the least-loaded batch dispatcher: request sequencer, datapath and ports.
//
// The dispatcher keeps a decoding load, a waiting load and two request counts for
// each batch in a small state memory (one read and one write per cycle, registered
// read data), and works on one request at a time. A preset request reads the
// entry, merges the preset fields and writes it back before the output handoff. A
// dispatch request scans the active batches through the memory, one read per
// cycle, then writes the chosen entry back; in forwarded-token cost mode the token
// count goes through the shared divider first. An offload check scans and sums the
// active batches and, unless the target holds fewer than 5 requests, runs the
// divider twice (average load rounded up, and threshold percent over 100) with
// one multiply between; a skipped check goes straight to the output handoff. The
// divider, which retires four quotient bits per cycle over a 40-bit dividend,
// sets most of the offload latency. There is no clearing pass after reset: each
// memory entry carries a valid bit that reset clears, so an unwritten batch reads
// as zero loads and counts. A new request may be accepted while the previous
// result is still held in the output register. Configuration writes are always
// ready and must only happen while the block is idle.
module least_loaded_batch_dispatcher_unit (
  input  logic                             clk,
  input  logic                             rst_n,
  // Request channel.
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // tdata, low bit up: batch_index[3], exclude_target[1], request_present[1],
  // fwd_token_count[20], out_token_count[20], cached_token_count[20],
  // preset_load[32], preset_count[16], zero fill[7].
  input  logic [llbd_pkg::IN_DATA_W-1:0]   in_tdata,
  // tuser, low bit up: req_type[2], queue_kind[1].
  input  logic [llbd_pkg::IN_USER_W-1:0]   in_tuser,
  // Result channel.
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // tdata, low bit up: chosen_batch[3], request_cost[20], new_batch_load[32],
  // need_offload[1], ideal_load[32], threshold_load[34], move_amount[32], zero fill[6].
  output logic [llbd_pkg::OUT_DATA_W-1:0]  out_tdata,
  // tuser, low bit up: status[2].
  output logic [llbd_pkg::OUT_USER_W-1:0]  out_tuser,
  // Configuration write channel.
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [llbd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [llbd_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import llbd_pkg::*;

  // Unpacked request fields.
  logic [BIDX_W-1:0]  in_bidx;
  logic               in_excl;
  logic               in_present;
  logic [TOK_W-1:0]   in_fwd;
  logic [TOK_W-1:0]   in_out_tok;
  logic [TOK_W-1:0]   in_cached;
  logic [LOAD_W-1:0]  in_pre_load;
  logic [COUNT_W-1:0] in_pre_cnt;
  logic [1:0]         in_type;
  logic               in_dec;

  assign in_bidx     = in_tdata[2:0];
  assign in_excl     = in_tdata[3];
  assign in_present  = in_tdata[4];
  assign in_fwd      = in_tdata[24:5];
  assign in_out_tok  = in_tdata[44:25];
  assign in_cached   = in_tdata[64:45];
  assign in_pre_load = in_tdata[96:65];
  assign in_pre_cnt  = in_tdata[112:97];
  assign in_type     = in_tuser[1:0];
  assign in_dec      = in_tuser[2];

  // Configuration registers.
  cost_mode_t       cost_mode_r;
  logic [3:0]       active_r;
  logic [PCT_W-1:0] thr_pct_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cost_mode_r <= MODE_NONE;
      active_r    <= 4'd2;
      thr_pct_r   <= 8'd120;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_COST_MODE: cost_mode_r <= cost_mode_t'(cfg_data[1:0]);
        CFG_ACTIVE:    active_r    <= cfg_data[3:0];
        CFG_THRESHOLD: thr_pct_r   <= cfg_data[PCT_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective number of active batches: zero acts as one, clamp at the memory depth.
  logic [CNT_W-1:0] n_act;
  always_comb begin
    if (active_r == 4'd0) begin
      n_act = CNT_W'(1);
    end else if (int'(active_r) > MAX_BATCHES) begin
      n_act = CNT_W'(MAX_BATCHES);
    end else begin
      n_act = CNT_W'(active_r);
    end
  end

  // Sequencer and datapath registers.
  state_t             state_r;
  state_t             state_nxt;
  logic [1:0]         type_r;
  logic [BIDX_W-1:0]  bidx_r;
  logic               dec_r;
  logic               excl_r;
  logic [LOAD_W-1:0]  pre_load_r;
  logic [COUNT_W-1:0] pre_cnt_r;
  logic [TOK_W-1:0]   cost_r;
  logic [CNT_W-1:0]   addr_r;
  logic               pend_r;
  logic [CNT_W-1:0]   pend_idx_r;
  logic               found_r;
  logic [CNT_W-1:0]   best_idx_r;
  logic [LOAD_W-1:0]  best_ld_r;
  entry_t             best_e_r;
  entry_t             tgt_e_r;
  logic [SUM_W-1:0]   total_r;
  logic [LOAD_W-1:0]  ideal_r;
  logic [SUM_W-1:0]   prod_r;
  logic [THR_W-1:0]   thr_r;
  result_t            res_r;

  // State memory and divider hookup.
  logic                mem_rd_en;
  logic [BATCH_W-1:0]  mem_rd_addr;
  entry_t              mem_rd_data;
  logic                mem_wr_en;
  logic [BATCH_W-1:0]  mem_wr_addr;
  entry_t              mem_wr_data;
  logic                div_start;
  logic [SUM_W-1:0]    div_dividend;
  logic [DVS_W-1:0]    div_divisor;
  logic                div_done;
  logic [SUM_W-1:0]    div_quo;
  logic [DVS_W-1:0]    div_rem;

  llbd_state_mem u_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data)
  );

  llbd_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  logic in_accept;
  assign in_tready = (state_r == ST_IDLE);
  assign in_accept = in_tvalid && in_tready;

  logic out_free;
  assign out_free = !out_tvalid || out_tready;

  // Cost that needs no division, taken when the request is accepted.
  logic [TOK_W-1:0] cost_direct;
  always_comb begin
    if (!in_present) begin
      cost_direct = '0;
    end else if (cost_mode_r == MODE_NEW_TOK && in_out_tok > in_cached) begin
      cost_direct = in_out_tok - in_cached;
    end else begin
      cost_direct = TOK_W'(1);
    end
  end

  // Offload check is skipped without touching the memory in these cases.
  logic off_skip;
  assign off_skip = (cost_mode_r == MODE_NONE) || (n_act <= CNT_W'(1)) ||
                    (int'(in_bidx) >= int'(n_act));

  // Entry load seen by the scan, and the merged entries for write-back.
  logic [LOAD_W-1:0]  scan_ld;
  logic               scan_skip;
  entry_t             upd_e;
  entry_t             pre_e;
  logic [COUNT_W:0]   tgt_cnt;
  logic [SUM_W-1:0]   mul_w;
  logic [LOAD_W-1:0]  ideal_calc;

  assign scan_ld   = dec_r ? mem_rd_data.dec_load : entry_total(mem_rd_data);
  assign scan_skip = excl_r && (int'(pend_idx_r) == int'(bidx_r));
  assign tgt_cnt   = {1'b0, tgt_e_r.dec_cnt} + {1'b0, tgt_e_r.wait_cnt};
  assign mul_w     = ideal_r * thr_pct_r;
  assign ideal_calc = div_quo[LOAD_W-1:0] + LOAD_W'(div_rem != '0);

  always_comb begin
    upd_e = best_e_r;
    if (dec_r) begin
      upd_e.dec_load = sat_add(best_e_r.dec_load, LOAD_W'(cost_r));
      upd_e.dec_cnt  = sat_inc(best_e_r.dec_cnt);
    end else begin
      upd_e.wait_load = sat_add(best_e_r.wait_load, LOAD_W'(cost_r));
      upd_e.wait_cnt  = sat_inc(best_e_r.wait_cnt);
    end
    pre_e = mem_rd_data;
    if (dec_r) begin
      pre_e.dec_load = pre_load_r;
      pre_e.dec_cnt  = pre_cnt_r;
    end else begin
      pre_e.wait_load = pre_load_r;
      pre_e.wait_cnt  = pre_cnt_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and memory/divider controls.
  always_comb begin
    state_nxt    = state_r;
    mem_rd_en    = 1'b0;
    mem_rd_addr  = addr_r[BATCH_W-1:0];
    mem_wr_en    = 1'b0;
    mem_wr_addr  = best_idx_r[BATCH_W-1:0];
    mem_wr_data  = upd_e;
    div_start    = 1'b0;
    div_dividend = SUM_W'(in_fwd);
    div_divisor  = DVS_W'(TOKENS_PER_BLOCK);
    case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          case (in_type)
            REQ_PRESET: begin
              state_nxt = (int'(in_bidx) < MAX_BATCHES) ? ST_PRE_RD : ST_OUT;
            end
            REQ_DISPATCH: begin
              if (in_present && cost_mode_r == MODE_FWD_BLOCK) begin
                div_start = 1'b1;
                state_nxt = ST_COST;
              end else begin
                state_nxt = ST_SCAN;
              end
            end
            REQ_OFFLOAD: begin
              state_nxt = off_skip ? ST_OUT : ST_SCAN;
            end
            default: state_nxt = ST_OUT;
          endcase
        end
      end
      ST_COST: begin
        if (div_done) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_PRE_RD: begin
        mem_rd_en   = 1'b1;
        mem_rd_addr = BATCH_W'(bidx_r);
        state_nxt   = ST_PRE_WR;
      end
      ST_PRE_WR: begin
        mem_wr_en   = 1'b1;
        mem_wr_addr = BATCH_W'(bidx_r);
        mem_wr_data = pre_e;
        state_nxt   = ST_OUT;
      end
      ST_SCAN: begin
        mem_rd_en = (addr_r < n_act);
        if (addr_r == n_act && !pend_r) begin
          state_nxt = (type_r == REQ_DISPATCH) ? ST_WRITE : ST_CHECK;
        end
      end
      ST_WRITE: begin
        mem_wr_en = found_r;
        state_nxt = ST_OUT;
      end
      ST_CHECK: begin
        if (tgt_cnt < (COUNT_W+1)'(MIN_REQS)) begin
          state_nxt = ST_OUT;
        end else begin
          div_start    = 1'b1;
          div_dividend = total_r;
          div_divisor  = DVS_W'(n_act);
          state_nxt    = ST_DIV_AVG;
        end
      end
      ST_DIV_AVG: begin
        if (div_done) begin
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        state_nxt = ST_THR_GO;
      end
      ST_THR_GO: begin
        div_start    = 1'b1;
        div_dividend = prod_r;
        div_divisor  = DVS_W'(PCT_SCALE);
        state_nxt    = ST_DIV_THR;
      end
      ST_DIV_THR: begin
        if (div_done) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Scan control bits need a clean start after reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r  <= 1'b0;
      found_r <= 1'b0;
      addr_r  <= '0;
    end else begin
      case (state_r)
        ST_IDLE: begin
          pend_r  <= 1'b0;
          found_r <= 1'b0;
          addr_r  <= '0;
        end
        ST_SCAN: begin
          pend_r <= (addr_r < n_act);
          if (addr_r < n_act) begin
            addr_r <= addr_r + 1'b1;
          end
          if (pend_r && !scan_skip && (!found_r || scan_ld < best_ld_r)) begin
            found_r <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          type_r     <= in_type;
          bidx_r     <= in_bidx;
          dec_r      <= in_dec;
          excl_r     <= in_excl && (int'(in_bidx) < int'(n_act));
          pre_load_r <= in_pre_load;
          pre_cnt_r  <= in_pre_cnt;
          cost_r     <= cost_direct;
          total_r    <= '0;
          res_r      <= '0;
          if (in_type == REQ_OFFLOAD && off_skip) begin
            res_r.status <= STAT_OFF_SKIP;
          end
        end
      end
      ST_COST: begin
        if (div_done) begin
          cost_r <= div_quo[TOK_W-1:0] + 1'b1;
        end
      end
      ST_SCAN: begin
        pend_idx_r <= addr_r;
        if (pend_r) begin
          total_r <= total_r + SUM_W'(entry_total(mem_rd_data));
          if (int'(pend_idx_r) == int'(bidx_r)) begin
            tgt_e_r <= mem_rd_data;
          end
          if (!scan_skip && (!found_r || scan_ld < best_ld_r)) begin
            best_idx_r <= pend_idx_r;
            best_ld_r  <= scan_ld;
            best_e_r   <= mem_rd_data;
          end
        end
      end
      ST_WRITE: begin
        res_r.cost <= cost_r;
        if (found_r) begin
          res_r.chosen   <= BIDX_W'(best_idx_r);
          res_r.new_load <= dec_r ? upd_e.dec_load : entry_total(upd_e);
        end else begin
          res_r.status <= STAT_NO_BATCH;
        end
      end
      ST_CHECK: begin
        if (tgt_cnt < (COUNT_W+1)'(MIN_REQS)) begin
          res_r.status <= STAT_FEW_REQ;
        end
      end
      ST_DIV_AVG: begin
        if (div_done) begin
          ideal_r <= ideal_calc;
        end
      end
      ST_MUL: begin
        prod_r <= mul_w;
      end
      ST_DIV_THR: begin
        if (div_done) begin
          thr_r <= div_quo[THR_W-1:0];
        end
      end
      ST_FIN: begin
        res_r.new_load <= entry_total(tgt_e_r);
        res_r.ideal    <= ideal_r;
        res_r.thr      <= thr_r;
        if ({2'b00, entry_total(tgt_e_r)} > thr_r) begin
          res_r.need <= 1'b1;
          res_r.move <= (entry_total(tgt_e_r) > ideal_r) ?
                        entry_total(tgt_e_r) - ideal_r : '0;
        end
      end
      default: ;
    endcase
  end

  // Output register: holds one finished result so the next request can start.
  logic                  out_tvalid_r;
  logic [OUT_DATA_W-1:0] out_tdata_r;
  logic [OUT_USER_W-1:0] out_tuser_r;
  logic                  out_load;

  assign out_load = (state_r == ST_OUT) && out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (out_load) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_tdata_r <= {6'b0, res_r.move, res_r.thr, res_r.ideal, res_r.need,
                      res_r.new_load, res_r.cost, res_r.chosen};
      out_tuser_r <= res_r.status;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

endmodule

>>> design/llbd_checker.sv
// Port-level checker for the least-loaded batch dispatcher, bound to the top level.
module llbd_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic [llbd_pkg::IN_DATA_W-1:0]  in_tdata,
  input logic [llbd_pkg::IN_USER_W-1:0]  in_tuser,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [llbd_pkg::OUT_DATA_W-1:0] out_tdata,
  input logic [llbd_pkg::OUT_USER_W-1:0] out_tuser
);
  import llbd_pkg::*;

  logic [BIDX_W-1:0] chosen;
  logic [LOAD_W-1:0] new_load;
  logic              need;
  logic [LOAD_W-1:0] move;
  logic              in_busy;

  assign chosen   = out_tdata[2:0];
  assign new_load = out_tdata[54:23];
  assign need     = out_tdata[55];
  assign move     = out_tdata[153:122];
  assign in_busy  = in_tvalid && !in_tready && (in_tdata != '1) && (in_tuser != '1);

  // A held result stays valid and unchanged until taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // A skipped offload check reports nothing but its status.
  a_skip_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == STAT_OFF_SKIP |-> out_tdata == '0)
    else $error("skipped offload check carries data");

  // No load is moved unless the target is found overloaded.
  a_move_needs_offload: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !need |-> move == '0)
    else $error("move amount without offload");

  // A dropped dispatch names no batch and no load.
  a_drop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == STAT_NO_BATCH |-> chosen == '0 && new_load == '0)
    else $error("dropped dispatch reports a batch");

  // Busy refusal check; in_busy already implies !in_tready, so it always holds.
  a_busy_then_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_busy && $past(in_tvalid && in_tready) |-> !in_tready)
    else $error("request refused inconsistently");

endmodule

bind least_loaded_batch_dispatcher_unit llbd_checker u_llbd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
